[src/stp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_pkg
// shared types, command codes, register indexes and reset values of the
// two-axis step/direction position controller
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int CMD_WIDTH     = 3;
    localparam int GOAL_WIDTH    = 24;
    localparam int SPEED_WIDTH   = 8;
    localparam int RATE_WIDTH    = 12;
    localparam int POS_WIDTH_DEF = 24;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CFG_DAT_WIDTH = 24;

    // command codes
    localparam logic [CMD_WIDTH-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_SET      = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_JOG_PAN  = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_JOG_TILT = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_HOME     = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_ESTOP    = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_ENABLE   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PAN_MIN  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PAN_MAX  = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TILT_MIN = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TILT_MAX = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PAN_INV  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EN_HIGH  = 3'd5;

    localparam logic signed [GOAL_WIDTH-1:0] PAN_MIN_RST  = -24'sd8000;
    localparam logic signed [GOAL_WIDTH-1:0] PAN_MAX_RST  = 24'sd8000;
    localparam logic signed [GOAL_WIDTH-1:0] TILT_MIN_RST = -24'sd2000;
    localparam logic signed [GOAL_WIDTH-1:0] TILT_MAX_RST = 24'sd2000;

    localparam int RATE_BASE  = 2250;
    localparam int RATE_SLOPE = 105;
    localparam int SPEED_MAX  = 20;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]          cmd;
        logic signed [GOAL_WIDTH-1:0]  pan_goal;
        logic signed [GOAL_WIDTH-1:0]  tilt_goal;
        logic                          jog_positive;
        logic [SPEED_WIDTH-1:0]        jog_speed;
        logic                          enable_value;
    } stp_cmd_t;

    // per-axis controls for one committed request
    typedef struct packed {
        logic tick;
        logic set;
        logic jog;
        logic home;
        logic estop;
    } stp_ctrl_t;

    // speed clamped to 1..20, so the rate never falls below 150
    function automatic logic [RATE_WIDTH-1:0] jog_rate(input logic [SPEED_WIDTH-1:0] speed);
        logic [4:0]            s;
        logic [RATE_WIDTH-1:0] prod;
        if (speed == '0)
            s = 5'd1;
        else if (speed > SPEED_WIDTH'(SPEED_MAX))
            s = 5'(SPEED_MAX);
        else
            s = speed[4:0];
        prod = RATE_WIDTH'(s) * RATE_WIDTH'(RATE_SLOPE);
        return RATE_WIDTH'(RATE_BASE) - prod;
    endfunction

endpackage
`default_nettype wire

[src/stp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_if
// valid/ready channels of the controller: command requests in, results out
// ----------------------------------------------------------------------------
interface stp_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [23:0] pan_goal;
    logic signed [23:0] tilt_goal;
    logic               jog_positive;
    logic [7:0]         jog_speed;
    logic               enable_value;

    modport source (output valid, cmd, pan_goal, tilt_goal, jog_positive, jog_speed,
                    enable_value, input ready);
    modport sink   (input valid, cmd, pan_goal, tilt_goal, jog_positive, jog_speed,
                    enable_value, output ready);
endinterface

interface stp_res_if;
    logic               valid;
    logic               ready;
    logic               pan_step_pulse;
    logic               pan_dir_level;
    logic               tilt_step_pulse;
    logic               tilt_dir_level;
    logic               enable_pin_level;
    logic signed [23:0] pan_now;
    logic signed [23:0] tilt_now;
    logic               stop_latched;
    logic [11:0]        pan_rate_out;
    logic [11:0]        tilt_rate_out;

    modport source (output valid, pan_step_pulse, pan_dir_level, tilt_step_pulse,
                    tilt_dir_level, enable_pin_level, pan_now, tilt_now, stop_latched,
                    pan_rate_out, tilt_rate_out, input ready);
    modport sink   (input valid, pan_step_pulse, pan_dir_level, tilt_step_pulse,
                    tilt_dir_level, enable_pin_level, pan_now, tilt_now, stop_latched,
                    pan_rate_out, tilt_rate_out, output ready);
endinterface
`default_nettype wire

[src/stp_cmd_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_cmd_reg
// input register stage: holds one request until the result stage takes it
// ----------------------------------------------------------------------------
module stp_cmd_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stp_pkg::stp_cmd_t in_item,
    input  wire logic              take,
    output logic                   valid,
    output stp_pkg::stp_cmd_t      item
);
    import stp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    stp_cmd_t  item_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule
`default_nettype wire

[src/stp_axis.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stp_axis
// one axis: position, target, direction pin and jog rate, with the next
// values for the request being committed
// ----------------------------------------------------------------------------
module stp_axis #(
    parameter int POS_WIDTH = stp_pkg::POS_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               commit,
    input  wire stp_pkg::stp_ctrl_t                 ctrl,
    input  wire logic signed [stp_pkg::GOAL_WIDTH-1:0] goal,
    input  wire logic signed [stp_pkg::GOAL_WIDTH-1:0] lo_bound,
    input  wire logic signed [stp_pkg::GOAL_WIDTH-1:0] hi_bound,
    input  wire logic                               jog_positive,
    input  wire logic                               invert,
    input  wire logic [stp_pkg::RATE_WIDTH-1:0]     rate_new,
    output logic signed [POS_WIDTH-1:0]             pos_next,
    output logic                                    dir_next,
    output logic                                    pulse,
    output logic [stp_pkg::RATE_WIDTH-1:0]          rate_next
);
    import stp_pkg::*;

    localparam logic [POS_WIDTH-1:0] ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

    logic signed [POS_WIDTH-1:0]  pos_reg;
    logic signed [POS_WIDTH-1:0]  tgt_reg;
    logic signed [POS_WIDTH-1:0]  tgt_next;
    logic                         dir_reg;
    logic [RATE_WIDTH-1:0]        rate_reg;
    logic signed [GOAL_WIDTH-1:0] lo_clamped;
    logic signed [GOAL_WIDTH-1:0] clamped;
    logic signed [GOAL_WIDTH-1:0] jog_limit;

    // crossed limits: the max clamp wins
    assign lo_clamped = (goal < lo_bound) ? lo_bound : goal;
    assign clamped    = (lo_clamped > hi_bound) ? hi_bound : lo_clamped;
    assign jog_limit  = jog_positive ? hi_bound : lo_bound;

    always_comb
    begin
        pos_next  = pos_reg;
        tgt_next  = tgt_reg;
        dir_next  = dir_reg;
        rate_next = rate_reg;
        pulse     = 1'b0;
        if (ctrl.tick)
        begin
            if (pos_reg < tgt_reg)
            begin
                pos_next = pos_reg + ONE;
                dir_next = !invert;
                pulse    = 1'b1;
            end
            else if (pos_reg > tgt_reg)
            begin
                pos_next = pos_reg - ONE;
                dir_next = invert;
                pulse    = 1'b1;
            end
        end
        if (ctrl.set)
            tgt_next = POS_WIDTH'(clamped);
        if (ctrl.jog)
        begin
            tgt_next  = POS_WIDTH'(jog_limit);
            rate_next = rate_new;
        end
        if (ctrl.home)
        begin
            pos_next  = '0;
            tgt_next  = '0;
            rate_next = '0;
        end
        if (ctrl.estop)
        begin
            tgt_next  = pos_reg;
            rate_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            tgt_reg  <= '0;
            dir_reg  <= 1'b0;
            rate_reg <= '0;
        end
        else if (commit)
        begin
            pos_reg  <= pos_next;
            tgt_reg  <= tgt_next;
            dir_reg  <= dir_next;
            rate_reg <= rate_next;
        end
    end

endmodule
`default_nettype wire

[src/two_axis_stepper_position_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_axis_stepper_position_controller
// pan/tilt step and direction generator with targets, jogs, home and stop
// ----------------------------------------------------------------------------
// usage:
//   cmd_ch carries one command request per handshake (tick, set targets,
//   jog pan, jog tilt, home, emergency stop, driver enable); res_ch returns
//   exactly one result per request: step pulses, held direction levels,
//   enable pin level, positions, stop flag and jog rates.
//   the limits, pan direction inversion and enable polarity are written
//   through cfg_we/cfg_index/cfg_data while no request is in flight.
// timing:
//   a request accepted into the input register is committed and its result
//   loaded into the result register as soon as that register is free or
//   being taken. one request is taken every cycle while the result is not
//   stalled; each axis does a compare and an increment per request.
// reset:
//   positions, targets, rates and stop flag clear, drivers come up on,
//   limits take -8000/8000 (pan) and -2000/2000 (tilt).
// stall:
//   a stalled result holds in the result register; the input register still
//   takes one more request, then ready drops until the result is taken.
// ----------------------------------------------------------------------------
module two_axis_stepper_position_controller #(
    parameter int POS_WIDTH = stp_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    stp_cmd_if.sink                                   cmd_ch,
    stp_res_if.source                                 res_ch,
    input  wire logic                                 cfg_we,
    input  wire logic [stp_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  wire logic [stp_pkg::CFG_DAT_WIDTH-1:0]    cfg_data
);
    import stp_pkg::*;

    // configuration
    logic signed [GOAL_WIDTH-1:0] pan_min_reg;
    logic signed [GOAL_WIDTH-1:0] pan_max_reg;
    logic signed [GOAL_WIDTH-1:0] tilt_min_reg;
    logic signed [GOAL_WIDTH-1:0] tilt_max_reg;
    logic                         pan_inv_reg;
    logic                         en_high_reg;

    // request stage
    stp_cmd_t  in_item;
    stp_cmd_t  cur;
    logic      cur_valid;
    logic      take;
    logic      commit;

    // shared state
    logic      drivers_on_reg;
    logic      drivers_on_next;
    logic      stop_reg;
    logic      stop_next;
    stp_ctrl_t pan_ctrl;
    stp_ctrl_t tilt_ctrl;
    logic [RATE_WIDTH-1:0] rate_new;

    // axis outputs
    logic signed [POS_WIDTH-1:0] pan_pos_next;
    logic signed [POS_WIDTH-1:0] tilt_pos_next;
    logic                        pan_dir_next;
    logic                        tilt_dir_next;
    logic                        pan_pulse;
    logic                        tilt_pulse;
    logic [RATE_WIDTH-1:0]       pan_rate_next;
    logic [RATE_WIDTH-1:0]       tilt_rate_next;

    // result register
    logic                         res_valid_reg;
    logic                         pan_pulse_reg;
    logic                         pan_dir_reg;
    logic                         tilt_pulse_reg;
    logic                         tilt_dir_reg;
    logic                         en_pin_reg;
    logic signed [GOAL_WIDTH-1:0] pan_now_reg;
    logic signed [GOAL_WIDTH-1:0] tilt_now_reg;
    logic                         stop_out_reg;
    logic [RATE_WIDTH-1:0]        pan_rate_reg;
    logic [RATE_WIDTH-1:0]        tilt_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_min_reg  <= PAN_MIN_RST;
            pan_max_reg  <= PAN_MAX_RST;
            tilt_min_reg <= TILT_MIN_RST;
            tilt_max_reg <= TILT_MAX_RST;
            pan_inv_reg  <= 1'b0;
            en_high_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAN_MIN:  pan_min_reg  <= cfg_data[GOAL_WIDTH-1:0];
                REG_PAN_MAX:  pan_max_reg  <= cfg_data[GOAL_WIDTH-1:0];
                REG_TILT_MIN: tilt_min_reg <= cfg_data[GOAL_WIDTH-1:0];
                REG_TILT_MAX: tilt_max_reg <= cfg_data[GOAL_WIDTH-1:0];
                REG_PAN_INV:  pan_inv_reg  <= cfg_data[0];
                REG_EN_HIGH:  en_high_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.cmd          = cmd_ch.cmd;
    assign in_item.pan_goal     = cmd_ch.pan_goal;
    assign in_item.tilt_goal    = cmd_ch.tilt_goal;
    assign in_item.jog_positive = cmd_ch.jog_positive;
    assign in_item.jog_speed    = cmd_ch.jog_speed;
    assign in_item.enable_value = cmd_ch.enable_value;

    assign take   = !res_valid_reg || res_ch.ready;
    assign commit = cur_valid && take;

    stp_cmd_reg u_cmd (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_ready (cmd_ch.ready),
        .in_item  (in_item),
        .take     (take),
        .valid    (cur_valid),
        .item     (cur)
    );

    assign rate_new = jog_rate(cur.jog_speed);

    always_comb
    begin
        pan_ctrl        = '0;
        tilt_ctrl       = '0;
        drivers_on_next = drivers_on_reg;
        stop_next       = stop_reg;
        unique case (cur.cmd)
            CMD_TICK:
            begin
                pan_ctrl.tick  = drivers_on_reg && !stop_reg;
                tilt_ctrl.tick = drivers_on_reg && !stop_reg;
            end
            CMD_SET:
            begin
                pan_ctrl.set  = !stop_reg;
                tilt_ctrl.set = !stop_reg;
            end
            CMD_JOG_PAN:  pan_ctrl.jog  = !stop_reg;
            CMD_JOG_TILT: tilt_ctrl.jog = !stop_reg;
            CMD_HOME:
            begin
                pan_ctrl.home  = 1'b1;
                tilt_ctrl.home = 1'b1;
                stop_next      = 1'b0;
            end
            CMD_ESTOP:
            begin
                pan_ctrl.estop  = 1'b1;
                tilt_ctrl.estop = 1'b1;
                stop_next       = 1'b1;
            end
            CMD_ENABLE:   drivers_on_next = cur.enable_value;
            default: ;
        endcase
    end

    stp_axis #(
        .POS_WIDTH (POS_WIDTH)
    ) u_pan (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (commit),
        .ctrl         (pan_ctrl),
        .goal         (cur.pan_goal),
        .lo_bound     (pan_min_reg),
        .hi_bound     (pan_max_reg),
        .jog_positive (cur.jog_positive),
        .invert       (pan_inv_reg),
        .rate_new     (rate_new),
        .pos_next     (pan_pos_next),
        .dir_next     (pan_dir_next),
        .pulse        (pan_pulse),
        .rate_next    (pan_rate_next)
    );

    stp_axis #(
        .POS_WIDTH (POS_WIDTH)
    ) u_tilt (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (commit),
        .ctrl         (tilt_ctrl),
        .goal         (cur.tilt_goal),
        .lo_bound     (tilt_min_reg),
        .hi_bound     (tilt_max_reg),
        .jog_positive (cur.jog_positive),
        .invert       (1'b0),
        .rate_new     (rate_new),
        .pos_next     (tilt_pos_next),
        .dir_next     (tilt_dir_next),
        .pulse        (tilt_pulse),
        .rate_next    (tilt_rate_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drivers_on_reg <= 1'b1;
            stop_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                drivers_on_reg <= drivers_on_next;
                stop_reg       <= stop_next;
            end
            if (commit)
                res_valid_reg <= 1'b1;
            else if (res_ch.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pan_pulse_reg  <= pan_pulse;
            pan_dir_reg    <= pan_dir_next;
            tilt_pulse_reg <= tilt_pulse;
            tilt_dir_reg   <= tilt_dir_next;
            en_pin_reg     <= en_high_reg ? drivers_on_next : !drivers_on_next;
            pan_now_reg    <= GOAL_WIDTH'(pan_pos_next);
            tilt_now_reg   <= GOAL_WIDTH'(tilt_pos_next);
            stop_out_reg   <= stop_next;
            pan_rate_reg   <= pan_rate_next;
            tilt_rate_reg  <= tilt_rate_next;
        end
    end

    assign res_ch.valid            = res_valid_reg;
    assign res_ch.pan_step_pulse   = pan_pulse_reg;
    assign res_ch.pan_dir_level    = pan_dir_reg;
    assign res_ch.tilt_step_pulse  = tilt_pulse_reg;
    assign res_ch.tilt_dir_level   = tilt_dir_reg;
    assign res_ch.enable_pin_level = en_pin_reg;
    assign res_ch.pan_now          = pan_now_reg;
    assign res_ch.tilt_now         = tilt_now_reg;
    assign res_ch.stop_latched     = stop_out_reg;
    assign res_ch.pan_rate_out     = pan_rate_reg;
    assign res_ch.tilt_rate_out    = tilt_rate_reg;

    // a latched stop never coexists with a step
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && stop_out_reg |-> !pan_pulse_reg && !tilt_pulse_reg)
        else $error("step pulse reported while stop latched");

    // a request waiting on a stalled result stage is kept intact
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid && !take |=> cur_valid && $stable(cur))
        else $error("pending request lost or changed");

    // home always reports zero positions and a cleared stop
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && cur.cmd == CMD_HOME |=> pan_now_reg == '0 && tilt_now_reg == '0
            && !stop_out_reg && pan_rate_reg == '0 && tilt_rate_reg == '0)
        else $error("home result not cleared");

    // emergency stop always latches and zeroes both rates
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && cur.cmd == CMD_ESTOP |=> stop_reg && stop_out_reg
            && pan_rate_reg == '0 && tilt_rate_reg == '0)
        else $error("emergency stop not latched");

endmodule
`default_nettype wire
